// ===== sv/range_min_max_query_tree_unit_defines.svh =====
// Assertion macros used by the checker file of the range min/max query tree.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef RANGE_MIN_MAX_QUERY_TREE_UNIT_DEFINES_SVH
`define RANGE_MIN_MAX_QUERY_TREE_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define RMMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that must be followed by the consequent in the next cycle.
`define RMMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rmmq_pkg.sv =====
// Package of the range min/max query tree: field widths, register indices and codes.
// No dependencies.
`default_nettype none

package rmmq_pkg;

  localparam int IDX_W     = 10;  // leaf index and range bound width
  localparam int CFG_W     = 11;  // widest configuration register
  localparam int CFG_IDX_W = 2;   // configuration register index width

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_OP_SELECT   = cfg_idx_t'(0);
  localparam cfg_idx_t REG_SIZE_IN_USE = cfg_idx_t'(1);

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic OP_MIN = 1'b0;
  localparam logic OP_MAX = 1'b1;

  localparam logic             OP_RESET   = OP_MAX;
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1024);

endpackage

`default_nettype wire

// ===== sv/rmmq_in_if.sv =====
// Input channel of the range min/max query tree: valid/ready with one request.
// Depends on rmmq_pkg.
`default_nettype none

interface rmmq_in_if
  import rmmq_pkg::*;
#(
  parameter int VALUE_WIDTH = 48
) ();

  logic                          valid;
  logic                          ready;
  logic                          func;
  logic        [IDX_W-1:0]       index;
  logic signed [VALUE_WIDTH-1:0] value;
  logic        [IDX_W-1:0]       range_left;
  logic        [IDX_W-1:0]       range_right;

  modport source (output valid, func, index, value, range_left, range_right,
                  input ready);
  modport sink   (input valid, func, index, value, range_left, range_right,
                  output ready);

endinterface

`default_nettype wire

// ===== sv/rmmq_out_if.sv =====
// Result channel of the range min/max query tree: valid/ready with one result.
// No dependencies beyond the value width parameter.
`default_nettype none

interface rmmq_out_if #(
  parameter int VALUE_WIDTH = 48
) ();

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] result_value;
  logic                          answered_query;
  logic                          rejected;

  modport source (output valid, result_value, answered_query, rejected, input ready);
  modport sink   (input valid, result_value, answered_query, rejected, output ready);

endinterface

`default_nettype wire

// ===== sv/range_min_max_query_tree_unit.sv =====
// Top level of the range min/max query tree: sequencer and node memory.
// Depends on rmmq_pkg, rmmq_in_if and rmmq_out_if.
//
//   Channel   Direction  Handshake           Carries
//   in_chan   sink       valid/ready         func, index, value, range_left, range_right
//   out_chan  source     valid/ready         result_value, answered_query, rejected
//   cfg_*     sink       write enable only   cfg_index, cfg_wdata (op_select, size_in_use)
//
// An update alternates S_UP_WR and S_UP_CMB for each tree level: each level writes the child
// node and reads its sibling through the single read port, and the root costs one more write.
// A query alternates S_Q_LO and S_Q_HI for each level, one for each range bound, and stops
// early when the bounds meet. Rejected items go straight from S_IDLE to S_EMIT.
// After reset and after each write to op_select or size_in_use the memory is swept to
// the neutral element, one node a cycle, across all 2*LEAF_COUNT nodes; no transfer on in_chan
// is taken meanwhile. A finished result sits in the output register, so the next item
// is accepted while the previous one still waits on a stalled out_chan.
`default_nettype none

module range_min_max_query_tree_unit
  import rmmq_pkg::*;
#(
  parameter int LEAF_COUNT  = 1024,
  parameter int VALUE_WIDTH = 48
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  rmmq_in_if.sink         in_chan,
  rmmq_out_if.source      out_chan,
  input  wire logic       cfg_we,
  input  wire cfg_idx_t   cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  // Node addresses: the leaves sit at LEAF_COUNT + i, node 1 is the root.
  localparam int NODE_COUNT = 2 * LEAF_COUNT;
  localparam int NW         = $clog2(NODE_COUNT);
  localparam int BW         = NW + 1;  // range bounds reach NODE_COUNT itself
  localparam int LCW        = $clog2(LEAF_COUNT + 1);
  localparam int CMPW       = (LCW > CFG_W) ? LCW : CFG_W;

  localparam logic [NW-1:0]   ROOT_NODE = NW'(1);
  localparam logic [NW-1:0]   LAST_NODE = NW'(NODE_COUNT - 1);
  localparam logic [CMPW-1:0] LEAF_CAP  = CMPW'(LEAF_COUNT);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UP_WR  = 6'b000010,
    S_UP_CMB = 6'b000100,
    S_Q_LO   = 6'b001000,
    S_Q_HI   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  // Configuration registers
  logic             op_r;
  logic [CFG_W-1:0] size_r;

  // Clearing sweep
  logic          clr_active_r;
  logic [NW-1:0] clr_addr_r;

  // Sequencer
  state_t        state_r, state_nxt;
  val_t          cur_r, cur_nxt;     // value climbing the tree during an update
  logic [NW-1:0] node_r, node_nxt;   // node being written during an update
  logic [BW-1:0] lo_r, lo_nxt;
  logic [BW-1:0] hi_r, hi_nxt;
  val_t          acc_r, acc_nxt;     // running combination of a query
  logic          pend_r, pend_nxt;   // read data waits to be folded into acc_r

  // Result staging and output register
  val_t res_val_r, res_val_nxt;
  logic res_ans_r, res_ans_nxt;
  logic res_rej_r, res_rej_nxt;
  logic out_valid_r;
  val_t out_val_r;
  logic out_ans_r;
  logic out_rej_r;

  // Node memory
  logic [VALUE_WIDTH-1:0] node_mem [NODE_COUNT];
  logic                   rd_en;
  logic [NW-1:0]          rd_addr;
  val_t                   rd_data_r;
  logic                   fsm_we;
  logic [NW-1:0]          fsm_waddr;
  val_t                   fsm_wdata;
  logic                   mem_we;
  logic [NW-1:0]          mem_waddr;
  val_t                   mem_wdata;

  logic            in_take;
  logic            out_load;
  logic            cfg_clear;
  val_t            neutral;
  logic [CMPW-1:0] active_size;
  val_t            acc_fold;
  logic [BW-1:0]   hi_dec;

  function automatic val_t combine(input logic op, input val_t a, input val_t b);
    if (op == OP_MAX) begin
      return (a < b) ? b : a;
    end
    return (b < a) ? b : a;
  endfunction

  // Most positive value for minimum, most negative for maximum.
  assign neutral = (op_r == OP_MAX) ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                    : {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  // A size beyond the tree's capacity acts as the capacity.
  assign active_size = (CMPW'(size_r) > LEAF_CAP) ? LEAF_CAP : CMPW'(size_r);

  assign cfg_clear = cfg_we && ((cfg_index == REG_OP_SELECT) ||
                                (cfg_index == REG_SIZE_IN_USE));

  assign in_chan.ready = (state_r == S_IDLE) && !clr_active_r;
  assign in_take       = in_chan.valid && in_chan.ready;

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_chan.ready);

  assign acc_fold = pend_r ? combine(op_r, acc_r, rd_data_r) : acc_r;
  assign hi_dec   = hi_r - BW'(1);

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    node_nxt    = node_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    acc_nxt     = acc_r;
    pend_nxt    = pend_r;
    res_val_nxt = res_val_r;
    res_ans_nxt = res_ans_r;
    res_rej_nxt = res_rej_r;
    rd_en       = 1'b0;
    rd_addr     = node_r ^ NW'(1);
    fsm_we      = 1'b0;
    fsm_waddr   = node_r;
    fsm_wdata   = cur_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_chan.func == FUNC_UPDATE) begin
            res_ans_nxt = 1'b0;
            res_val_nxt = '0;
            if (CMPW'(in_chan.index) >= active_size) begin
              res_rej_nxt = 1'b1;
              state_nxt   = S_EMIT;
            end else begin
              res_rej_nxt = 1'b0;
              cur_nxt     = in_chan.value;
              node_nxt    = NW'(in_chan.index) + NW'(LEAF_COUNT);
              state_nxt   = S_UP_WR;
            end
          end else begin
            res_ans_nxt = 1'b1;
            if ((in_chan.range_left > in_chan.range_right) ||
                (CMPW'(in_chan.range_right) >= active_size)) begin
              res_val_nxt = neutral;
              res_rej_nxt = 1'b1;
              state_nxt   = S_EMIT;
            end else begin
              res_rej_nxt = 1'b0;
              lo_nxt      = BW'(in_chan.range_left) + BW'(LEAF_COUNT);
              hi_nxt      = BW'(in_chan.range_right) + BW'(LEAF_COUNT) + BW'(1);
              acc_nxt     = neutral;
              pend_nxt    = 1'b0;
              state_nxt   = S_Q_LO;
            end
          end
        end
      end

      // Write the current node, then fetch its sibling unless it is the root.
      S_UP_WR: begin
        fsm_we = 1'b1;
        if (node_r == ROOT_NODE) begin
          state_nxt = S_EMIT;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_UP_CMB;
        end
      end

      S_UP_CMB: begin
        cur_nxt   = combine(op_r, cur_r, rd_data_r);
        node_nxt  = node_r >> 1;
        state_nxt = S_UP_WR;
      end

      // Left bound: fold any pending read, then test the loop and the left edge.
      S_Q_LO: begin
        if (lo_r >= hi_r) begin
          res_val_nxt = acc_fold;
          state_nxt   = S_EMIT;
        end else begin
          acc_nxt = acc_fold;
          if (lo_r[0]) begin
            rd_en    = 1'b1;
            rd_addr  = lo_r[NW-1:0];
            lo_nxt   = lo_r + BW'(1);
            pend_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
          end
          state_nxt = S_Q_HI;
        end
      end

      // Right bound: fold the left read, fetch the right edge, climb one level.
      S_Q_HI: begin
        acc_nxt = acc_fold;
        lo_nxt  = lo_r >> 1;
        if (hi_r[0]) begin
          rd_en    = 1'b1;
          rd_addr  = hi_dec[NW-1:0];
          hi_nxt   = hi_dec >> 1;
          pend_nxt = 1'b1;
        end else begin
          hi_nxt   = hi_r >> 1;
          pend_nxt = 1'b0;
        end
        state_nxt = S_Q_LO;
      end

      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The sweep owns the write port while it runs; a sequencer write in that time is dropped.
  assign mem_we    = clr_active_r || fsm_we;
  assign mem_waddr = clr_active_r ? clr_addr_r : fsm_waddr;
  assign mem_wdata = clr_active_r ? neutral : fsm_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= val_t'(node_mem[rd_addr]);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r         <= OP_RESET;
      size_r       <= SIZE_RESET;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      state_r      <= S_IDLE;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_OP_SELECT)) begin
        op_r <= cfg_wdata[0];
      end
      if (cfg_we && (cfg_index == REG_SIZE_IN_USE)) begin
        size_r <= cfg_wdata;
      end

      // A write to op_select or size_in_use restarts the sweep under the new neutral element.
      if (cfg_clear) begin
        clr_active_r <= 1'b1;
        clr_addr_r   <= '0;
      end else if (clr_active_r) begin
        if (clr_addr_r == LAST_NODE) begin
          clr_active_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + NW'(1);
      end

      state_r <= state_nxt;
      pend_r  <= pend_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    node_r    <= node_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    acc_r     <= acc_nxt;
    res_val_r <= res_val_nxt;
    res_ans_r <= res_ans_nxt;
    res_rej_r <= res_rej_nxt;
    if (out_load) begin
      out_val_r <= res_val_r;
      out_ans_r <= res_ans_r;
      out_rej_r <= res_rej_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.result_value   = out_val_r;
  assign out_chan.answered_query = out_ans_r;
  assign out_chan.rejected       = out_rej_r;

endmodule

`default_nettype wire

// ===== sv/rmmq_checker.sv =====
// Port-level checks of the range min/max query tree, bound to its top level.
// Depends on rmmq_pkg and range_min_max_query_tree_unit_defines.svh.
`default_nettype none

`include "range_min_max_query_tree_unit_defines.svh"

module rmmq_port_checker
  import rmmq_pkg::*;
#(
  parameter int VALUE_WIDTH = 48
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [VALUE_WIDTH-1:0] out_result_value,
  input wire logic                   out_answered_query,
  input wire logic                   cfg_we,
  input wire cfg_idx_t               cfg_index
);

  logic in_xfer;
  logic cfg_clear;
  logic update_out;

  assign in_xfer    = in_valid && in_ready;
  assign cfg_clear  = cfg_we && ((cfg_index == REG_OP_SELECT) ||
                                 (cfg_index == REG_SIZE_IN_USE));
  assign update_out = out_valid && !out_answered_query;

  // A result waiting on a stalled sink stays offered.
  `RMMQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

  // The sequencer works on one item at a time.
  `RMMQ_ASSERT_NEXT(a_busy_after_take, in_xfer, !in_ready, "ready held after a transfer")

  // A write to op_select or size_in_use starts the clearing sweep, which blocks new items.
  `RMMQ_ASSERT_NEXT(a_clear_blocks, cfg_clear, !in_ready, "item taken during clearing")

  // Update results always carry a zero value.
  `RMMQ_ASSERT(a_update_zero, !update_out || (out_result_value == '0), "update not zero")

  // A fresh result only follows a busy cycle of the sequencer.
  `RMMQ_ASSERT(a_result_after_work, !$rose(out_valid) || $past(!in_ready), "result idle")

endmodule

bind range_min_max_query_tree_unit rmmq_port_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_rmmq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_result_value  (out_chan.result_value),
  .out_answered_query(out_chan.answered_query),
  .cfg_we            (cfg_we),
  .cfg_index         (cfg_index)
);

`default_nettype wire
